// ----- rtl/core/countdown_timer_controller_assert.svh -----
// Assertion macros used by the countdown timer checker
`ifndef COUNTDOWN_TIMER_CONTROLLER_ASSERT_SVH
`define COUNTDOWN_TIMER_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define CTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("countdown timer check failed");

// Next-cycle implication, sampled on clk, held off during reset
`define CTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("countdown timer check failed");

`endif

// ----- rtl/core/ctc_pkg.sv -----
// Types, codes and segment decoding for the countdown timer controller
package ctc_pkg;

    typedef enum logic [6:0] {
        ST_BEEP       = 7'b0000001,
        ST_WAIT_PRESS = 7'b0000010,
        ST_HELD       = 7'b0000100,
        ST_COUNT      = 7'b0001000,
        ST_RING       = 7'b0010000,
        ST_WAIT_REL   = 7'b0100000,
        ST_SETTLE     = 7'b1000000
    } state_t;

    localparam logic [2:0] MODE_BEEP       = 3'd0;
    localparam logic [2:0] MODE_WAIT_PRESS = 3'd1;
    localparam logic [2:0] MODE_HELD       = 3'd2;
    localparam logic [2:0] MODE_COUNT      = 3'd3;
    localparam logic [2:0] MODE_RING       = 3'd4;
    localparam logic [2:0] MODE_WAIT_REL   = 3'd5;
    localparam logic [2:0] MODE_SETTLE     = 3'd6;

    localparam logic [2:0] REG_INITIAL_SECONDS       = 3'd0;
    localparam logic [2:0] REG_SET_STEP              = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS_TICKS      = 3'd2;
    localparam logic [2:0] REG_COUNT_PERIOD_TICKS    = 3'd3;
    localparam logic [2:0] REG_ITERATIONS_PER_SECOND = 3'd4;
    localparam logic [2:0] REG_RING_TOGGLE_TICKS     = 3'd5;
    localparam logic [2:0] REG_STARTUP_BEEP_TICKS    = 3'd6;
    localparam logic [2:0] REG_SETTLE_TICKS          = 3'd7;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [7:0] SECONDS_WRAP = 8'd100;

    typedef struct packed {
        logic [6:0]  initial_seconds;
        logic [6:0]  set_step;
        logic [7:0]  long_press_ticks;
        logic [7:0]  count_period_ticks;
        logic [7:0]  iterations_per_second;
        logic [9:0]  ring_toggle_ticks;
        logic [15:0] startup_beep_ticks;
        logic [7:0]  settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic       buzzer_on;
        logic       tens_digit_on;
        logic       ones_digit_on;
        logic [7:0] segment_byte;
        logic       refresh_strobe;
        logic [6:0] seconds_left;
        logic [2:0] mode;
    } result_t;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h81;
            4'd1:    seg = 8'hCF;
            4'd2:    seg = 8'h92;
            4'd3:    seg = 8'h86;
            4'd4:    seg = 8'hCC;
            4'd5:    seg = 8'hA4;
            4'd6:    seg = 8'hA0;
            4'd7:    seg = 8'h8F;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h84;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ----- rtl/core/ctc_cfg_regs.sv -----
// Configuration register file of the countdown timer controller
module ctc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output ctc_pkg::cfg_t                       cfg
);
    import ctc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_seconds       <= 7'd5;
            cfg_reg.set_step              <= 7'd5;
            cfg_reg.long_press_ticks      <= 8'd200;
            cfg_reg.count_period_ticks    <= 8'd10;
            cfg_reg.iterations_per_second <= 8'd100;
            cfg_reg.ring_toggle_ticks     <= 10'd100;
            cfg_reg.startup_beep_ticks    <= 16'd500;
            cfg_reg.settle_ticks          <= 8'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INITIAL_SECONDS:       cfg_reg.initial_seconds       <= cfg_data[6:0];
                REG_SET_STEP:              cfg_reg.set_step              <= cfg_data[6:0];
                REG_LONG_PRESS_TICKS:      cfg_reg.long_press_ticks      <= cfg_data[7:0];
                REG_COUNT_PERIOD_TICKS:    cfg_reg.count_period_ticks    <= cfg_data[7:0];
                REG_ITERATIONS_PER_SECOND: cfg_reg.iterations_per_second <= cfg_data[7:0];
                REG_RING_TOGGLE_TICKS:     cfg_reg.ring_toggle_ticks     <= cfg_data[9:0];
                REG_STARTUP_BEEP_TICKS:    cfg_reg.startup_beep_ticks    <= cfg_data[15:0];
                REG_SETTLE_TICKS:          cfg_reg.settle_ticks          <= cfg_data[7:0];
                default:                   cfg_reg                       <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- rtl/core/ctc_core.sv -----
// Mode state machine, timers and display decode of the countdown timer controller
module ctc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              pressed,
    input  ctc_pkg::cfg_t     cfg,
    output ctc_pkg::result_t  result
);
    import ctc_pkg::*;

    state_t      state_reg,   state_next;
    logic [6:0]  seconds_reg, seconds_next;
    logic [7:0]  press_reg,   press_next;
    logic [15:0] div_reg,     div_next;
    logic [7:0]  iter_reg,    iter_next;
    logic        buzzer_reg,  buzzer_next;
    logic        ones_reg,    ones_next;

    logic        strobe;
    logic [15:0] div_inc;
    logic [15:0] limit;
    logic [15:0] hold_div;
    logic [15:0] count_adv;
    logic [15:0] ring_adv;
    logic [7:0]  iter_inc;
    logic [7:0]  step_sum;
    logic        show;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones_full;
    logic [2:0]  mode_code;

    always_comb
    begin
        div_inc   = div_reg + 16'd1;
        iter_inc  = iter_reg + 8'd1;
        step_sum  = {1'b0, seconds_reg} + {1'b0, cfg.set_step};
        limit     = (state_reg == ST_BEEP) ? cfg.startup_beep_ticks
                                           : {8'h00, cfg.settle_ticks};
        hold_div  = (div_reg < limit) ? div_inc : div_reg;
        count_adv = (div_inc >= {8'h00, cfg.count_period_ticks}) ? 16'd0 : div_inc;
        ring_adv  = (div_inc >= {6'h00, cfg.ring_toggle_ticks}) ? 16'd0 : div_inc;

        state_next   = state_reg;
        seconds_next = seconds_reg;
        press_next   = press_reg;
        div_next     = div_reg;
        iter_next    = iter_reg;
        buzzer_next  = buzzer_reg;
        ones_next    = ones_reg;
        strobe       = 1'b0;

        unique case (state_reg) inside
            ST_BEEP, ST_SETTLE:
            begin
                if (hold_div >= limit)
                begin
                    div_next     = 16'd0;
                    state_next   = ST_WAIT_PRESS;
                    seconds_next = cfg.initial_seconds;
                    buzzer_next  = 1'b0;
                end
                else
                begin
                    div_next = hold_div;
                end
            end
            ST_WAIT_PRESS:
            begin
                if (pressed)
                begin
                    state_next  = ST_HELD;
                    buzzer_next = 1'b1;
                    press_next  = (cfg.long_press_ticks != 8'd0) ? 8'd1 : 8'd0;
                end
            end
            ST_HELD:
            begin
                if (pressed)
                begin
                    if (press_reg < cfg.long_press_ticks)
                    begin
                        press_next = press_reg + 8'd1;
                    end
                end
                else
                begin
                    buzzer_next = 1'b0;
                    if (press_reg >= cfg.long_press_ticks)
                    begin
                        state_next = ST_COUNT;
                        div_next   = 16'd0;
                        iter_next  = 8'd0;
                    end
                    else
                    begin
                        seconds_next = (step_sum >= SECONDS_WRAP) ? 7'd0 : step_sum[6:0];
                        state_next   = ST_WAIT_PRESS;
                    end
                end
            end
            ST_COUNT:
            begin
                if (div_reg != 16'd0)
                begin
                    div_next = count_adv;
                end
                else if (pressed)
                begin
                    state_next  = ST_WAIT_REL;
                    buzzer_next = 1'b0;
                    ones_next   = 1'b0;
                end
                else if ((iter_inc >= cfg.iterations_per_second) && (seconds_reg == 7'd0))
                begin
                    iter_next  = 8'd0;
                    state_next = ST_RING;
                    div_next   = 16'd0;
                    ones_next  = 1'b0;
                end
                else
                begin
                    if (iter_inc >= cfg.iterations_per_second)
                    begin
                        iter_next    = 8'd0;
                        seconds_next = seconds_reg - 7'd1;
                    end
                    else
                    begin
                        iter_next = iter_inc;
                    end
                    ones_next = !ones_reg;
                    strobe    = 1'b1;
                    div_next  = count_adv;
                end
            end
            ST_RING:
            begin
                if ((div_reg == 16'd0) && pressed)
                begin
                    buzzer_next = 1'b0;
                    state_next  = ST_WAIT_REL;
                end
                else
                begin
                    if (div_reg == 16'd0)
                    begin
                        buzzer_next = !buzzer_reg;
                    end
                    div_next = ring_adv;
                end
            end
            ST_WAIT_REL:
            begin
                if (!pressed)
                begin
                    state_next = ST_SETTLE;
                    div_next   = 16'd0;
                end
            end
            default:
            begin
                div_next     = 16'd0;
                state_next   = ST_WAIT_PRESS;
                seconds_next = cfg.initial_seconds;
                buzzer_next  = 1'b0;
            end
        endcase

        if ((state_next == ST_WAIT_PRESS) || (state_next == ST_HELD))
        begin
            ones_next = !ones_next;
            strobe    = 1'b1;
        end
    end

    // Split seconds into digits: tens = floor(s * 205 / 2048) holds for s below 128
    always_comb
    begin
        show      = (state_next == ST_WAIT_PRESS) || (state_next == ST_HELD)
                 || (state_next == ST_COUNT);
        tens_prod = 15'(seconds_next) * 15'd205;
        tens      = tens_prod[14:11];
        tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
        ones_full = seconds_next - tens_x10;

        unique case (state_next)
            ST_BEEP:       mode_code = MODE_BEEP;
            ST_WAIT_PRESS: mode_code = MODE_WAIT_PRESS;
            ST_HELD:       mode_code = MODE_HELD;
            ST_COUNT:      mode_code = MODE_COUNT;
            ST_RING:       mode_code = MODE_RING;
            ST_WAIT_REL:   mode_code = MODE_WAIT_REL;
            ST_SETTLE:     mode_code = MODE_SETTLE;
            default:       mode_code = MODE_WAIT_PRESS;
        endcase

        result.buzzer_on      = buzzer_next;
        result.tens_digit_on  = show && ones_next;
        result.ones_digit_on  = show && !ones_next;
        result.segment_byte   = !show    ? 8'h00
                              : ones_next ? seg_of(tens)
                              :             seg_of(ones_full[3:0]);
        result.refresh_strobe = strobe;
        result.seconds_left   = seconds_next;
        result.mode           = mode_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_BEEP;
            seconds_reg <= 7'd0;
            press_reg   <= 8'd0;
            div_reg     <= 16'd0;
            iter_reg    <= 8'd0;
            buzzer_reg  <= 1'b1;
            ones_reg    <= 1'b0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            seconds_reg <= seconds_next;
            press_reg   <= press_next;
            div_reg     <= div_next;
            iter_reg    <= iter_next;
            buzzer_reg  <= buzzer_next;
            ones_reg    <= ones_next;
        end
    end

endmodule

// ----- rtl/core/countdown_timer_controller.sv -----
// Top level of the countdown timer controller: tick register, core and result register
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid / in_ready       button_pressed
//  out      source     out_valid / out_ready     buzzer_on .. mode
//  cfg      sink       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One tick per cycle unless the output stalls: tick register, one pass of mode logic, result register.
// Result valid is set by the edge that loads the result register from the tick register.
// A full result register stalls processing; the tick register still takes one more request.
// Reset puts the block in the start-up beep with the buzzer on; configuration is always ready.
module countdown_timer_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                button_pressed,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                buzzer_on,
    output logic                                tens_digit_on,
    output logic                                ones_digit_on,
    output logic [7:0]                          segment_byte,
    output logic                                refresh_strobe,
    output logic [6:0]                          seconds_left,
    output logic [2:0]                          mode,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ctc_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t result_reg;
    logic    tick_valid_reg;
    logic    button_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = tick_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !tick_valid_reg || advance;

    ctc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ctc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pressed (button_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                tick_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            button_reg <= button_pressed;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign buzzer_on      = result_reg.buzzer_on;
    assign tens_digit_on  = result_reg.tens_digit_on;
    assign ones_digit_on  = result_reg.ones_digit_on;
    assign segment_byte   = result_reg.segment_byte;
    assign refresh_strobe = result_reg.refresh_strobe;
    assign seconds_left   = result_reg.seconds_left;
    assign mode           = result_reg.mode;

endmodule

// ----- rtl/core/ctc_checker.sv -----
// Port-level checker of the countdown timer controller and its bind
`include "countdown_timer_controller_assert.svh"

module ctc_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       buzzer_on,
    input  logic       tens_digit_on,
    input  logic       ones_digit_on,
    input  logic [7:0] segment_byte,
    input  logic       refresh_strobe,
    input  logic [6:0] seconds_left,
    input  logic [2:0] mode
);
    import ctc_pkg::*;

    logic shown_mode;
    logic dark_mode;

    assign shown_mode = (mode == MODE_WAIT_PRESS) || (mode == MODE_HELD)
                     || (mode == MODE_COUNT);
    assign dark_mode  = (mode == MODE_BEEP) || (mode == MODE_RING)
                     || (mode == MODE_WAIT_REL) || (mode == MODE_SETTLE);

    `CTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(buzzer_on) && $stable(segment_byte)
        && $stable(seconds_left) && $stable(mode) && $stable(refresh_strobe)
        && $stable(tens_digit_on) && $stable(ones_digit_on))
    `CTC_ASSERT_NOW(a_dark_display, out_valid && dark_mode,
        !tens_digit_on && !ones_digit_on && (segment_byte == 8'h00))
    `CTC_ASSERT_NOW(a_one_digit, out_valid && shown_mode, tens_digit_on != ones_digit_on)
    `CTC_ASSERT_NOW(a_strobe_mode, out_valid && refresh_strobe, shown_mode)

endmodule

bind countdown_timer_controller ctc_checker u_ctc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .buzzer_on      (buzzer_on),
    .tens_digit_on  (tens_digit_on),
    .ones_digit_on  (ones_digit_on),
    .segment_byte   (segment_byte),
    .refresh_strobe (refresh_strobe),
    .seconds_left   (seconds_left),
    .mode           (mode)
);
